### hw/rtl/positional_list_store_defines.svh
// Assertion helpers used by the list store RTL.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pls_pkg.sv
package pls_pkg;

	localparam int CAPACITY_DEF = 16;

	// command codes
	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_LOAD   = 3'd1;
	localparam logic [2:0] CMD_DUMP   = 3'd2;
	localparam logic [2:0] CMD_INSERT = 3'd3;
	localparam logic [2:0] CMD_DELETE = 3'd4;
	localparam logic [2:0] CMD_SEARCH = 3'd5;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_BADPOS   = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// cell operations
	localparam logic [2:0] OP_HOLD   = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_INSERT = 3'd2;
	localparam logic [2:0] OP_DELETE = 3'd3;
	localparam logic [2:0] OP_ROTATE = 3'd4;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] value;
		logic [4:0]         position;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] data;
		logic [4:0]         count;
		logic               last;
	} rsp_t;

endpackage

### hw/rtl/positional_list_store.sv
// Bounded ordered list of signed 32-bit values held in a chain of CAPACITY
// cells, cell 0 holding list position 1. Commands: clear, load (append),
// dump, insert and delete at a 1-based position, and search for the first
// matching position. Every command but dump gives one transfer on rsp with
// last set; dump gives one transfer per element (or one EMPTY transfer).
// Codes 6 and 7 are dropped silently. A command is registered when taken
// and executed in S_EXEC; clear, load, insert and delete end there. Dump
// and search on a non-empty list go on to S_ROT, in which the occupied
// cells rotate one place per cycle past cell 0, where the head is read
// out or compared, and a full turn puts the order back. S_EXEC and
// rotation pause while the output register is held by rsp_stall. A new
// command is taken as soon as the previous one has finished, even while its
// last transfer still waits on rsp. Entry storage is not cleared by reset;
// only cells below the count are ever read.
`include "positional_list_store_defines.svh"

module positional_list_store import pls_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_ROT  = 2'd2;

	// control state
	logic [1:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] idx_q, idx_d;
	logic          found_q, found_d;
	logic          rsp_valid_q;

	// command and result payload
	logic [2:0]    cmd_q;
	logic [31:0]   val_q;
	logic [4:0]    pos_q;
	logic [IW-1:0] fpos_q, fpos_d;
	rsp_t          rsp_q, rsp_d;

	// cell chain
	logic [31:0]   cell_q [CAPACITY];
	logic [2:0]    cell_op;
	logic [IW-1:0] cell_sel;
	logic [IW-1:0] cell_lim;

	logic            load_ok;
	logic            emit;
	logic [CMPW-1:0] pos_w, cnt_w;
	logic            full, empty, ins_ok, del_ok;
	logic [IW-1:0]   last_idx;
	logic            last_step;
	logic            hit;
	logic [IW-1:0]   hit_pos;

	assign req_stall = (state_q != S_IDLE);
	// output register can take a new result this cycle
	assign load_ok   = !rsp_valid_q || !rsp_stall;

	assign pos_w  = CMPW'(pos_q);
	assign cnt_w  = CMPW'(count_q);
	assign full   = (cnt_w >= CMPW'(CAPACITY));
	assign empty  = (count_q == '0);
	assign ins_ok = (pos_w >= CMPW'(1)) && (pos_w <= cnt_w + CMPW'(1));
	assign del_ok = (pos_w >= CMPW'(1)) && (pos_w <= cnt_w);

	assign last_idx  = IW'(count_q - CW'(1));
	assign last_step = (idx_q == last_idx);
	assign hit       = (cell_q[0] == val_q);
	assign hit_pos   = found_q ? fpos_q : idx_q;

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		found_d  = found_q;
		fpos_d   = fpos_q;
		cell_op  = OP_HOLD;
		cell_sel = '0;
		cell_lim = '0;
		emit     = 1'b0;
		rsp_d    = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (load_ok) begin
					state_d      = S_IDLE;
					emit         = 1'b1;
					rsp_d.status = ST_OK;
					rsp_d.last   = 1'b1;
					case (cmd_q)
						CMD_CLEAR: begin
							count_d = '0;
						end
						CMD_LOAD: begin
							if (full) begin
								rsp_d.status = ST_FULL;
							end else begin
								cell_op  = OP_WRITE;
								cell_sel = IW'(count_q);
								count_d  = count_q + CW'(1);
							end
						end
						CMD_DUMP: begin
							if (empty) begin
								rsp_d.status = ST_EMPTY;
							end else begin
								emit    = 1'b0;
								state_d = S_ROT;
								idx_d   = '0;
							end
						end
						CMD_INSERT: begin
							if (full) begin
								rsp_d.status = ST_FULL;
							end else if (!ins_ok) begin
								rsp_d.status = ST_BADPOS;
							end else begin
								cell_op  = OP_INSERT;
								cell_sel = IW'(pos_w - CMPW'(1));
								count_d  = count_q + CW'(1);
							end
						end
						CMD_DELETE: begin
							if (empty) begin
								rsp_d.status = ST_EMPTY;
							end else if (!del_ok) begin
								rsp_d.status = ST_BADPOS;
							end else begin
								cell_op  = OP_DELETE;
								cell_sel = IW'(pos_w - CMPW'(1));
								count_d  = count_q - CW'(1);
							end
						end
						CMD_SEARCH: begin
							if (empty) begin
								rsp_d.status = ST_NOTFOUND;
							end else begin
								emit    = 1'b0;
								state_d = S_ROT;
								idx_d   = '0;
								found_d = 1'b0;
							end
						end
						default: begin
							emit = 1'b0;
						end
					endcase
					rsp_d.count = 5'(count_d);
				end
			end
			S_ROT: begin
				if (load_ok) begin
					cell_op  = OP_ROTATE;
					cell_lim = last_idx;
					idx_d    = idx_q + IW'(1);
					if (cmd_q == CMD_DUMP) begin
						emit         = 1'b1;
						rsp_d.status = ST_OK;
						rsp_d.data   = cell_q[0];
						rsp_d.last   = last_step;
					end else begin
						if (hit && !found_q) begin
							found_d = 1'b1;
							fpos_d  = idx_q;
						end
						if (last_step) begin
							emit       = 1'b1;
							rsp_d.last = 1'b1;
							if (found_q || hit) begin
								rsp_d.status = ST_OK;
								rsp_d.data   = 32'(hit_pos) + 32'd1;
							end else begin
								rsp_d.status = ST_NOTFOUND;
							end
						end
					end
					rsp_d.count = 5'(count_q);
					if (last_step) state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			found_q <= found_d;
			if (emit) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			cmd_q <= req.cmd;
			val_q <= req.value;
			pos_q <= req.position;
		end
		fpos_q <= fpos_d;
		if (emit) rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// chain of cells; cell k holds list position k+1
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [31:0] left_w, right_w;
		if (k == 0) begin : g_first
			assign left_w = cell_q[0];
		end else begin : g_mid
			assign left_w = cell_q[k-1];
		end
		if (k == CAPACITY - 1) begin : g_end
			assign right_w = cell_q[k];
		end else begin : g_inner
			assign right_w = cell_q[k+1];
		end
		pls_cell #(
			.IW  (IW),
			.IDX (k)
		) u_cell (
			.clk   (clk),
			.op    (cell_op),
			.sel   (cell_sel),
			.lim   (cell_lim),
			.value (val_q),
			.left  (left_w),
			.right (right_w),
			.head  (cell_q[0]),
			.q     (cell_q[k])
		);
	end

	`PLS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY), "count past capacity")
	`PLS_ASSERT_NOW(a_rot_nonempty, clk, arst_n, state_q == S_ROT, count_q != '0, "rotation on empty list")
	`PLS_ASSERT_NOW(a_rot_index, clk, arst_n, state_q == S_ROT, idx_q <= last_idx, "rotation index past last entry")
	`PLS_ASSERT_NEXT(a_take_exec, clk, arst_n, req_valid && !req_stall, state_q == S_EXEC, "accepted command not executed")

endmodule

### hw/rtl/pls_cell.sv
module pls_cell import pls_pkg::*; #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic [2:0]    op,
	input  logic [IW-1:0] sel,
	input  logic [IW-1:0] lim,
	input  logic [31:0]   value,
	input  logic [31:0]   left,
	input  logic [31:0]   right,
	input  logic [31:0]   head,
	output logic [31:0]   q
);

	localparam logic [IW-1:0] K = IW'(IDX);

	logic [31:0] entry_q;
	logic [31:0] entry_d;

	always_comb begin
		entry_d = entry_q;
		case (op)
			OP_WRITE: begin
				if (K == sel) entry_d = value;
			end
			OP_INSERT: begin
				if (K > sel) entry_d = left;
				else if (K == sel) entry_d = value;
			end
			OP_DELETE: begin
				if (K >= sel) entry_d = right;
			end
			OP_ROTATE: begin
				// head wraps in at the last occupied cell
				if (K < lim) entry_d = right;
				else if (K == lim) entry_d = head;
			end
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign q = entry_q;

endmodule

### sim/positional_list_store_tb.sv
`timescale 1ns / 1ps

// Testbench for positional_list_store.
// A shadow copy of the list is kept in the bench and updated at each accepted
// command transfer. The answers it predicts are queued in order and checked
// field by field against every accepted rsp transfer. Stimulus is a short
// directed table, then shaped random commands under several idle/stall mixes,
// and finally a long rsp hold-off so the block backs up into req_stall.
module positional_list_store_tb;
	import pls_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	// unused command codes, the block must drop them silently
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;
	localparam logic signed [31:0] VAL_MIN = 32'h8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'h7fff_ffff;
	// cycles without any transfer before the run is declared hung
	localparam int QUIET_LIMIT = 2000;
	// drain time after the last answer: a full dump plus pipeline slack
	localparam int DRAIN_CYCLES = 40;

	// one row of the directed table; want is only used when typed is set
	typedef struct {
		req_t op;
		bit   typed;
		rsp_t want;
	} plan_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// shadow of the list contents and fill level
	logic signed [31:0] shadow_list [CAP];
	int shadow_count = 0;

	// answers predicted but not yet seen on rsp, oldest first
	rsp_t answers_due [$];

	int send_idle_pct = 0;	// chance per cycle the sender sits idle
	int stall_pct = 0;	// chance per cycle the receiver stalls
	int hold_cycles = 0;	// pending forced stall run, counted down below
	int mismatches = 0;
	int cmds_in = 0;
	int answers_out = 0;

	positional_list_store dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	function automatic req_t make_req(logic [2:0] c, logic signed [31:0] v, logic [4:0] p);
		req_t r;
		r.cmd = c;
		r.value = v;
		r.position = p;
		return r;
	endfunction

	function automatic plan_t plain(logic [2:0] c, logic signed [31:0] v, logic [4:0] p);
		plan_t s;
		s.op = make_req(c, v, p);
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	// row whose single answer is written out by hand
	function automatic plan_t known(logic [2:0] c, logic signed [31:0] v, logic [4:0] p,
			logic [2:0] st, logic signed [31:0] d, logic [4:0] n);
		plan_t s;
		s = plain(c, v, p);
		s.typed = 1'b1;
		s.want.status = st;
		s.want.data = d;
		s.want.count = n;
		s.want.last = 1'b1;
		return s;
	endfunction

	// Applies one command to the shadow list and queues the answers it gives.
	// Dump yields one answer per element; codes 6/7 yield none.
	function automatic void run_list_cmd(input req_t r);
		rsp_t a;
		int p;
		int hit;
		a = '0;
		a.last = 1'b1;
		p = int'(r.position);
		case (r.cmd)
		CMD_CLEAR: begin
			shadow_count = 0;
			a.status = ST_OK;
		end
		CMD_LOAD: begin
			if (shadow_count >= CAP) begin
				a.status = ST_FULL;
			end else begin
				shadow_list[shadow_count] = r.value;
				shadow_count++;
				a.status = ST_OK;
			end
		end
		CMD_DUMP: begin
			if (shadow_count == 0) begin
				a.status = ST_EMPTY;
			end else begin
				for (int i = 0; i < shadow_count; i++) begin
					a.status = ST_OK;
					a.data = shadow_list[i];
					a.count = 5'(shadow_count);
					a.last = (i == shadow_count - 1);
					answers_due.push_back(a);
				end
				return;
			end
		end
		CMD_INSERT: begin
			// full takes precedence over a bad position
			if (shadow_count >= CAP) begin
				a.status = ST_FULL;
			end else if (p < 1 || p > shadow_count + 1) begin
				a.status = ST_BADPOS;
			end else begin
				for (int i = shadow_count; i > p - 1; i--)
					shadow_list[i] = shadow_list[i - 1];
				shadow_list[p - 1] = r.value;
				shadow_count++;
				a.status = ST_OK;
			end
		end
		CMD_DELETE: begin
			// empty takes precedence over a bad position
			if (shadow_count == 0) begin
				a.status = ST_EMPTY;
			end else if (p < 1 || p > shadow_count) begin
				a.status = ST_BADPOS;
			end else begin
				for (int i = p - 1; i + 1 < shadow_count; i++)
					shadow_list[i] = shadow_list[i + 1];
				shadow_count--;
				a.status = ST_OK;
			end
		end
		CMD_SEARCH: begin
			hit = 0;
			for (int i = 0; i < shadow_count; i++)
				if (hit == 0 && shadow_list[i] == r.value)
					hit = i + 1;
			a.status = (hit != 0) ? ST_OK : ST_NOTFOUND;
			a.data = hit;
		end
		default: return;
		endcase
		a.count = 5'(shadow_count);
		answers_due.push_back(a);
	endfunction

	// small values often, so searches hit duplicates and first-match matters
	function automatic logic signed [31:0] draw_value();
		int near_zero;
		near_zero = int'($urandom_range(6)) - 3;
		if ($urandom_range(2) == 0)
			return near_zero;
		return $urandom;
	endfunction

	// Random command shaped by the current shadow state: mostly legal edits,
	// searches for stored values and dumps, plus some noise and bad positions.
	function automatic req_t next_cmd();
		int roll;
		int n;
		roll = $urandom_range(99);
		n = shadow_count;
		if (roll < 10)
			return make_req(3'($urandom_range(7)), $urandom, 5'($urandom_range(31)));
		if (roll < 30)
			return make_req(CMD_LOAD, draw_value(), 5'($urandom_range(31)));
		if (roll < 48 && n < CAP)
			return make_req(CMD_INSERT, draw_value(), 5'($urandom_range(n + 1, 1)));
		if (roll < 64 && n > 0)
			return make_req(CMD_DELETE, draw_value(), 5'($urandom_range(n, 1)));
		if (roll < 80) begin
			if (n > 0 && $urandom_range(2) != 0)
				return make_req(CMD_SEARCH, shadow_list[$urandom_range(n - 1)],
					5'($urandom_range(31)));
			return make_req(CMD_SEARCH, draw_value(), 5'($urandom_range(31)));
		end
		if (roll < 88)
			return make_req(CMD_DUMP, $urandom, 5'($urandom_range(31)));
		if (roll < 92)
			return make_req(CMD_CLEAR, $urandom, 5'($urandom_range(31)));
		// broken edit: position drawn over the whole field
		return make_req($urandom_range(1) ? CMD_INSERT : CMD_DELETE, draw_value(),
			5'($urandom_range(31)));
	endfunction

	// Offers one command and holds it until the transfer happens, then updates
	// the shadow. Called right after a rising edge; exits on the accepting edge.
	task automatic send_cmd(input req_t c, input bit typed, input rsp_t want);
		int slot;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= c;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		slot = answers_due.size();
		run_list_cmd(c);
		// a hand-written answer stands in for the predicted one
		if (typed && answers_due.size() > slot)
			answers_due[slot] = want;
		cmds_in++;
	endtask

	// Fills the list to capacity, then pokes at every full-list corner.
	task automatic fill_and_probe();
		rsp_t none;
		none = '0;
		send_cmd(make_req(CMD_CLEAR, draw_value(), 5'($urandom_range(31))), 1'b0, none);
		while (shadow_count < CAP)
			send_cmd(make_req(CMD_LOAD, draw_value(), 5'($urandom_range(31))), 1'b0, none);
		send_cmd(make_req(CMD_LOAD, draw_value(), 5'd0), 1'b0, none);
		send_cmd(make_req(CMD_INSERT, draw_value(), 5'd1), 1'b0, none);
		send_cmd(make_req(CMD_INSERT, draw_value(), 5'd0), 1'b0, none);	// full beats bad pos
		send_cmd(make_req(CMD_DUMP, 0, 5'd0), 1'b0, none);
		send_cmd(make_req(CMD_SEARCH, shadow_list[CAP - 1], 5'd0), 1'b0, none);
		send_cmd(make_req(CMD_DELETE, 0, 5'(CAP + 1)), 1'b0, none);
		send_cmd(make_req(CMD_DELETE, 0, 5'(CAP)), 1'b0, none);
		send_cmd(make_req(CMD_INSERT, draw_value(), 5'(CAP)), 1'b0, none);
		send_cmd(make_req(CMD_DELETE, 0, 5'd1), 1'b0, none);
	endtask

	// Receiver: a forced hold-off run takes priority, otherwise random stalls.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Result checker: every accepted rsp transfer against the oldest answer due.
	always @(posedge clk) begin : check_rsp
		rsp_t due;
		if (arst_n && rsp_valid && !rsp_stall) begin
			answers_out++;
			if (answers_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result status=%0d data=%0d",
					rsp.status, rsp.data));
			end else begin
				due = answers_due.pop_front();
				if (rsp.status !== due.status)
					flag_mismatch($sformatf("status %0d, want %0d", rsp.status, due.status));
				if (rsp.data !== due.data)
					flag_mismatch($sformatf("data %0d, want %0d", rsp.data, due.data));
				if (rsp.count !== due.count)
					flag_mismatch($sformatf("count %0d, want %0d", rsp.count, due.count));
				if (rsp.last !== due.last)
					flag_mismatch($sformatf("last %0b, want %0b", rsp.last, due.last));
			end
		end
	end

	// Watchdog: ends the run if neither channel moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: %0d answers still due", answers_due.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		plan_t plan [$];
		rsp_t none;
		none = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Typed rows carry their answer; the rest are predicted.
		plan.push_back(known(CMD_DUMP, 0, 5'd0, ST_EMPTY, 0, 5'd0));	// empty dump
		plan.push_back(known(CMD_DELETE, 0, 5'd0, ST_EMPTY, 0, 5'd0));	// empty beats bad pos
		plan.push_back(known(CMD_SEARCH, 0, 5'd0, ST_NOTFOUND, 0, 5'd0));	// search on empty
		plan.push_back(known(CMD_INSERT, 7, 5'd0, ST_BADPOS, 0, 5'd0));
		plan.push_back(known(CMD_INSERT, 7, 5'd2, ST_BADPOS, 0, 5'd0));	// past count+1
		plan.push_back(known(CMD_INSERT, VAL_MIN, 5'd1, ST_OK, 0, 5'd1));
		plan.push_back(known(CMD_LOAD, VAL_MAX, 5'd31, ST_OK, 0, 5'd2));	// position ignored
		plan.push_back(known(CMD_LOAD, -1, 5'd0, ST_OK, 0, 5'd3));
		plan.push_back(known(CMD_INSERT, 0, 5'd4, ST_OK, 0, 5'd4));	// insert at tail
		plan.push_back(known(CMD_INSERT, 5, 5'd2, ST_OK, 0, 5'd5));	// shifts the rest up
		plan.push_back(plain(CMD_DUMP, 0, 5'd0));
		plan.push_back(known(CMD_SEARCH, VAL_MAX, 5'd0, ST_OK, 3, 5'd5));
		plan.push_back(plain(CMD_SEARCH, 0, 5'd0));
		plan.push_back(known(CMD_SEARCH, 12345, 5'd0, ST_NOTFOUND, 0, 5'd5));
		plan.push_back(known(CMD_DELETE, 0, 5'd0, ST_BADPOS, 0, 5'd5));
		plan.push_back(known(CMD_DELETE, 0, 5'd6, ST_BADPOS, 0, 5'd5));	// count+1
		plan.push_back(known(CMD_DELETE, 0, 5'd31, ST_BADPOS, 0, 5'd5));
		plan.push_back(known(CMD_INSERT, 9, 5'd7, ST_BADPOS, 0, 5'd5));	// count+2
		plan.push_back(known(CMD_DELETE, 0, 5'd1, ST_OK, 0, 5'd4));	// head, shifts down
		plan.push_back(plain(CMD_DELETE, 0, 5'd4));	// tail
		plan.push_back(plain(CMD_SPARE6, -1, 5'd31));	// dropped, no answer
		plan.push_back(plain(CMD_SPARE7, 0, 5'd0));
		plan.push_back(plain(CMD_DUMP, 0, 5'd0));
		plan.push_back(known(CMD_CLEAR, 0, 5'd0, ST_OK, 0, 5'd0));
		plan.push_back(known(CMD_DUMP, 0, 5'd0, ST_EMPTY, 0, 5'd0));
		foreach (plan[k])
			send_cmd(plan[k].op, plan[k].typed, plan[k].want);

		// Random part: no idling, sender gaps, receiver stalls, then both.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 72;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 72;
			end
			default: begin
				send_idle_pct = 36;
				stall_pct = 36;
			end
			endcase
			if (ph == 0 || ph == 3)
				fill_and_probe();
			repeat (20)
				send_cmd(next_cmd(), 1'b0, none);
		end

		// Back-pressure: receiver holds off while commands keep coming, so the
		// output register fills and req_stall must rise and hold the transfer.
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 80;
		repeat (12)
			send_cmd(next_cmd(), 1'b0, none);
		req_valid <= 1'b0;

		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands sent, %0d results checked across idle-free, gapped, stalled,",
			cmds_in, answers_out);
		$display("mixed and held-off traffic, incl. full/empty/bad-position/not-found cases");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/pls_pkg.sv
hw/rtl/pls_cell.sv
hw/rtl/positional_list_store.sv
sim/positional_list_store_tb.sv
